### src/fcc_pkg.sv
package fcc_pkg;

   // 1.0 in the Q1.16 normalized level
   localparam int QONE = 65536;
   localparam logic [16:0] Q_ONE = 17'(QONE);

   typedef enum logic [1:0] {
      MAP_JET  = 2'd0,
      MAP_HOT  = 2'd1,
      MAP_GRAY = 2'd2,
      MAP_RAMP = 2'd3
   } map_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rgb_type;

   // trunc(q * 255 / 65536) for a Q.16 level, zero when q is not positive
   function automatic logic [7:0] lvl(input logic signed [19:0] q);
      logic [27:0] t;
      begin
         t = 28'(q[18:0]) * 28'd255;
         if (q <= 20'sd0) begin
            lvl = 8'd0;
         end else begin
            lvl = t[23:16];
         end
      end
   endfunction

endpackage

### src/fcc_map.sv
module fcc_map (
   input  logic [16:0]      level,
   input  fcc_pkg::map_type sel,
   output fcc_pkg::rgb_type color
);

   localparam logic signed [19:0] P1_8 = 20'(fcc_pkg::QONE / 8);
   localparam logic signed [19:0] P1_4 = 20'(fcc_pkg::QONE / 4);
   localparam logic signed [19:0] P3_8 = 20'(fcc_pkg::QONE * 3 / 8);
   localparam logic signed [19:0] P1_2 = 20'(fcc_pkg::QONE / 2);
   localparam logic signed [19:0] P5_8 = 20'(fcc_pkg::QONE * 5 / 8);
   localparam logic signed [19:0] P3_4 = 20'(fcc_pkg::QONE * 3 / 4);
   localparam logic signed [19:0] P7_8 = 20'(fcc_pkg::QONE * 7 / 8);
   localparam logic signed [19:0] P3_2 = 20'(fcc_pkg::QONE * 3 / 2);
   localparam logic signed [19:0] P2   = 20'(fcc_pkg::QONE * 2);
   localparam logic signed [19:0] P5_2 = 20'(fcc_pkg::QONE * 5 / 2);
   localparam logic signed [19:0] P3   = 20'(fcc_pkg::QONE * 3);
   localparam logic signed [19:0] P7_2 = 20'(fcc_pkg::QONE * 7 / 2);
   localparam logic signed [19:0] P4   = 20'(fcc_pkg::QONE * 4);
   localparam logic signed [19:0] P9_2 = 20'(fcc_pkg::QONE * 9 / 2);

   always_comb begin
      logic signed [19:0] ns;
      logic signed [19:0] n4;
      logic [24:0]        hot_r;
      logic [24:0]        hot_g;
      logic [7:0]         r;
      logic [7:0]         g;
      logic [7:0]         b;
      ns    = signed'({3'b000, level});
      n4    = ns <<< 2;
      // hot ramps: n * 255 / (3/8) / 65536 == n * 85 >> 13
      hot_r = 25'(level) * 25'd85;
      hot_g = 25'(level - 17'(P3_8)) * 25'd85;
      r     = 8'd0;
      g     = 8'd0;
      b     = 8'd0;
      case (sel)
         fcc_pkg::MAP_JET: begin
            if (ns > P3_8) begin
               if (ns < P5_8) r = fcc_pkg::lvl(n4 - P3_2);
               else if (ns > P7_8) r = fcc_pkg::lvl(P9_2 - n4);
               else r = 8'd255;
            end
            if (ns > P1_8) begin
               if (ns < P3_8) g = fcc_pkg::lvl(n4 - P1_2);
               else if (ns < P5_8) g = 8'd255;
               else if (ns < P7_8) g = fcc_pkg::lvl(P7_2 - n4);
            end
            if (ns < P1_8) b = fcc_pkg::lvl(P1_2 + n4);
            else if (ns < P3_8) b = 8'd255;
            else if (ns < P5_8) b = fcc_pkg::lvl(P5_2 - n4);
         end
         fcc_pkg::MAP_HOT: begin
            r = 8'd255;
            if (ns < P3_8) begin
               r = hot_r[20:13];
            end else if (ns < P3_4) begin
               g = hot_g[20:13];
            end else begin
               b = fcc_pkg::lvl(n4 - P3);
               g = 8'd255;
            end
         end
         fcc_pkg::MAP_GRAY: begin
            r = fcc_pkg::lvl(ns);
            g = r;
            b = r;
         end
         fcc_pkg::MAP_RAMP: begin
            g = 8'd255;
            if (ns > P3_4) begin
               r = 8'd255;
               g = fcc_pkg::lvl(P4 - n4);
            end else if (ns > P1_2) begin
               r = fcc_pkg::lvl(n4 - P2);
            end else if (ns > P1_4) begin
               b = fcc_pkg::lvl(P2 - n4);
            end else if (ns > 20'sd0) begin
               g = fcc_pkg::lvl(n4);
               b = 8'd255;
            end else begin
               g = 8'd0;
               b = 8'd255;
            end
         end
         default: begin
            r = 8'd0;
         end
      endcase
      color.red   = r;
      color.green = g;
      color.blue  = b;
   end

endmodule

### src/false_color_colormap_core.sv
// false color colormap core: one signed Q16.16 sample in, one 8-bit RGB pixel out.
// input channel req_valid / req_stall / req_sample; a transfer happens on a clock
// edge with req_valid high and req_stall low. result channel rsp_valid / rsp_stall
// with rsp_red, rsp_green, rsp_blue, same transfer rule.
// csr channel: csr_valid / csr_ready / csr_index / csr_data. index 0 display_low,
// 1 inverse_range, 2 map_select, 3 ignored. csr_ready is always high. write only
// while the pipe is empty.
// pipe: subtract floor, 32x32 scale multiply, saturate to Q1.16, colormap lookup
// into the output register. rsp_valid is out_valid_ff, fed by v1_ff, v2_ff, v3_ff.
// throughput: one pixel per clock unless stalled; the multiplier is the long path.
// each stage holds its item while the one after is full and stalled, and empty
// stages still fill, so req_stall rises only once every stage holds a pixel.
// reset (synchronous) empties the pipe and loads display_low 0, inverse_range 1.0
// and the jet map.
module false_color_colormap_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_sample,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [7:0]         rsp_red,
   output logic [7:0]         rsp_green,
   output logic [7:0]         rsp_blue,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_data
);

   localparam logic [1:0] CSR_DISPLAY_LOW   = 2'd0;
   localparam logic [1:0] CSR_INVERSE_RANGE = 2'd1;
   localparam logic [1:0] CSR_MAP_SELECT    = 2'd2;

   logic signed [31:0] display_low_ff;
   logic [31:0]        inverse_range_ff;
   fcc_pkg::map_type   map_select_ff;

   logic               v1_ff, v2_ff, v3_ff, out_valid_ff;
   logic               rdy1, rdy2, rdy3, out_rdy;
   logic [31:0]        d_ff, d_in;
   logic [63:0]        prod_ff, prod_in;
   logic [16:0]        n_ff, n_in;
   fcc_pkg::rgb_type   rgb_ff, rgb_in;
   logic signed [32:0] diff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         display_low_ff   <= 32'sd0;
         inverse_range_ff <= 32'h0100_0000;
         map_select_ff    <= fcc_pkg::MAP_JET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_DISPLAY_LOW:   display_low_ff   <= signed'(csr_data);
            CSR_INVERSE_RANGE: inverse_range_ff <= csr_data;
            CSR_MAP_SELECT:    map_select_ff    <= fcc_pkg::map_type'(csr_data[1:0]);
            default: begin
            end
         endcase
      end
   end

   // per-stage ready so bubbles close up behind a stalled output
   assign out_rdy   = !out_valid_ff || !rsp_stall;
   assign rdy3      = !v3_ff || out_rdy;
   assign rdy2      = !v2_ff || rdy3;
   assign rdy1      = !v1_ff || rdy2;
   assign req_stall = !rdy1;

   // stage 1: distance above the floor, zero at or below it
   assign diff = {req_sample[31], req_sample} - {display_low_ff[31], display_low_ff};
   assign d_in = (diff[32] || diff == 33'sd0) ? 32'd0 : diff[31:0];

   // stage 2: Q24.40 product
   assign prod_in = 64'(d_ff) * 64'(inverse_range_ff);

   // stage 3: truncate to Q1.16 and saturate at 1.0
   assign n_in = (prod_ff[63:24] > 40'(fcc_pkg::Q_ONE)) ? fcc_pkg::Q_ONE : prod_ff[40:24];

   fcc_map u_map (
      .level (n_ff),
      .sel   (map_select_ff),
      .color (rgb_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (out_rdy) out_valid_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1 && req_valid) d_ff <= d_in;
      if (rdy2 && v1_ff) prod_ff <= prod_in;
      if (rdy3 && v2_ff) n_ff <= n_in;
      if (out_rdy && v3_ff) rgb_ff <= rgb_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_red   = rgb_ff.red;
   assign rsp_green = rgb_ff.green;
   assign rsp_blue  = rgb_ff.blue;

   a_level_range: assert property (@(posedge clock) disable iff (reset)
      v3_ff |-> n_ff <= fcc_pkg::Q_ONE)
      else $error("normalized level above 1.0");

   a_bubble_accepts: assert property (@(posedge clock) disable iff (reset)
      !v1_ff |-> !req_stall)
      else $error("input stalled with an empty first stage");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !v1_ff && !v2_ff && !v3_ff)
      else $error("pipe not empty after reset");

   a_stalled_stage_holds: assert property (@(posedge clock) disable iff (reset)
      v3_ff && !rdy3 |=> v3_ff && $stable(n_ff))
      else $error("level stage changed while blocked");

endmodule
